// ===== sv/abg_pkg.sv =====
// shared constants, register codes and helpers of the anchor box generator
`timescale 1ns / 1ps
package abg_pkg;

	localparam int TABLE_LANES     = 4;
	localparam int DEF_MAX_RATIOS  = 4;
	localparam int DEF_MAX_SIZES   = 4;

	localparam int CFG_DATA_W      = 64;
	localparam int CFG_INDEX_W     = 3;
	localparam int LANE_W          = 16;
	localparam int LANE_IDX_W      = 2;
	localparam int CELL_W          = 12;
	localparam int STRIDE_W        = 10;
	localparam int OFFSET_W        = 8;
	localparam int COUNT_W         = 3;
	localparam int COORD_W         = 28;

	localparam int BW_W            = 16;
	localparam int BH_W            = 25;
	localparam int RDIV_N          = 32;
	localparam int CDIV_N          = 44;
	localparam int SQRT_W          = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RATIO_TABLE    = 3'd0,
		REG_SIZE_TABLE     = 3'd1,
		REG_RATIO_COUNT    = 3'd2,
		REG_SIZE_COUNT     = 3'd3,
		REG_STRIDE_X       = 3'd4,
		REG_STRIDE_Y       = 3'd5,
		REG_CENTER_OFFSET  = 3'd6,
		REG_VARIANCE_TABLE = 3'd7
	} cfg_idx_t;

	localparam logic [CFG_DATA_W-1:0] RST_RATIO_TABLE    = 64'd256;
	localparam logic [CFG_DATA_W-1:0] RST_SIZE_TABLE     = 64'd32;
	localparam logic [COUNT_W-1:0]    RST_COUNT          = 3'd1;
	localparam logic [STRIDE_W-1:0]   RST_STRIDE         = 10'd16;
	localparam logic [OFFSET_W-1:0]   RST_CENTER_OFFSET  = 8'd128;
	localparam logic [CFG_DATA_W-1:0] RST_VARIANCE_TABLE = 64'd0;

	function automatic logic [LANE_W-1:0] lane16(input logic [CFG_DATA_W-1:0] word,
		input logic [LANE_IDX_W-1:0] lane);
		return word[{lane, 4'b0000} +: LANE_W];
	endfunction

endpackage

// ===== sv/abg_ram.sv =====
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps
module abg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/abg_div.sv =====
// iterative unsigned divider, four quotient bits per cycle
`timescale 1ns / 1ps
module abg_div #(
	parameter int N = 32,
	parameter int M = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [M-1:0] divisor,
	output logic         done,
	output logic [N-1:0] quot,
	output logic [M-1:0] rem
);

	localparam int STEPS = N / 4;
	localparam int CW = $clog2(STEPS + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [N-1:0]  work_q;
	logic [M-1:0]  rem_q;
	logic [M-1:0]  div_q;

	logic [N-1:0]  work_nx;
	logic [M-1:0]  rem_nx;
	logic [M:0]    trial;

	always_comb begin
		work_nx = work_q;
		rem_nx  = rem_q;
		trial   = '0;
		for (int k = 0; k < 4; k++) begin
			trial   = {rem_nx, work_nx[N-1]};
			work_nx = {work_nx[N-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_nx     = M'(trial - {1'b0, div_q});
				work_nx[0] = 1'b1;
			end else begin
				rem_nx = trial[M-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			work_q <= work_nx;
			rem_q  <= rem_nx;
		end
	end

	assign done = done_q;
	assign quot = work_q;
	assign rem  = rem_q;

endmodule

// ===== sv/abg_sqrt.sv =====
// iterative integer square root, one result bit per cycle
`timescale 1ns / 1ps
module abg_sqrt #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   operand,
	output logic           done,
	output logic [W/2-1:0] root
);

	localparam int RW = W / 2;
	localparam int REMW = RW + 2;
	localparam int CW = $clog2(RW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  val_q;
	logic [RW-1:0] res_q;
	logic [REMW-1:0] rem_q;

	logic [REMW+1:0] tval;
	logic [REMW+1:0] tsub;
	logic            take;

	assign tval = {rem_q, val_q[W-1:W-2]};
	assign tsub = (REMW+2)'({res_q, 2'b01});
	assign take = tval >= tsub;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= operand;
			res_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[W-3:0], 2'b00};
			if (take) begin
				rem_q <= REMW'(tval - tsub);
				res_q <= {res_q[RW-2:0], 1'b1};
			end else begin
				rem_q <= tval[REMW-1:0];
				res_q <= {res_q[RW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = res_q;

endmodule

// ===== sv/anchor_box_generator_core.sv =====
// anchor box generator top level: config registers, sequencer and corner math
//
//  channel | signals                              | beat
//  --------+--------------------------------------+------------------------------
//  config  | wr_en wr_index wr_data               | one register write per wr_en
//  cell in | in_valid in_stall row col            | one feature-map cell
//  box out | out_valid out_stall x_min..last_anchor | one anchor box per beat
//
//  a cell runs the ratio divider and square root once per ratio lane, then the
//  four-bit-per-cycle corner dividers once per anchor
//  per-ratio base extents are kept in a small ram and read back once per anchor
//  in_stall is high while a cell is in work; a new cell is taken once the last
//  box sits in the output register, even while that box is stalled
//  reset clears the sequencer and loads the register defaults
module anchor_box_generator_core
	import abg_pkg::*;
#(
	parameter int MAX_RATIOS = DEF_MAX_RATIOS,
	parameter int MAX_SIZES  = DEF_MAX_SIZES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [CFG_INDEX_W-1:0]     wr_index,
	input  logic [CFG_DATA_W-1:0]      wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [CELL_W-1:0]          row,
	input  logic [CELL_W-1:0]          col,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [COORD_W-1:0]  x_min,
	output logic signed [COORD_W-1:0]  y_min,
	output logic signed [COORD_W-1:0]  x_max,
	output logic signed [COORD_W-1:0]  y_max,
	output logic [LANE_W-1:0]          var_a,
	output logic [LANE_W-1:0]          var_b,
	output logic [LANE_W-1:0]          var_c,
	output logic [LANE_W-1:0]          var_d,
	output logic                       last_anchor
);

	localparam int RLIM = (MAX_RATIOS < TABLE_LANES) ? MAX_RATIOS : TABLE_LANES;
	localparam int SLIM = (MAX_SIZES < TABLE_LANES) ? MAX_SIZES : TABLE_LANES;
	localparam int RAW  = (RLIM > 1) ? $clog2(RLIM) : 1;
	localparam int RAMW = BW_W + BH_W;

	typedef enum logic [3:0] {
		S_IDLE, S_CENTER, S_RSTART, S_RDIV, S_SQRT, S_BH,
		S_READ, S_MUL, S_DSTART, S_DIV, S_FIN
	} state_t;

	// configuration registers
	logic [CFG_DATA_W-1:0] ratio_table_q;
	logic [CFG_DATA_W-1:0] size_table_q;
	logic [COUNT_W-1:0]    ratio_count_q;
	logic [COUNT_W-1:0]    size_count_q;
	logic [STRIDE_W-1:0]   stride_x_q;
	logic [STRIDE_W-1:0]   stride_y_q;
	logic [OFFSET_W-1:0]   center_offset_q;
	logic [CFG_DATA_W-1:0] variance_table_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_table_q    <= RST_RATIO_TABLE;
			size_table_q     <= RST_SIZE_TABLE;
			ratio_count_q    <= RST_COUNT;
			size_count_q     <= RST_COUNT;
			stride_x_q       <= RST_STRIDE;
			stride_y_q       <= RST_STRIDE;
			center_offset_q  <= RST_CENTER_OFFSET;
			variance_table_q <= RST_VARIANCE_TABLE;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RATIO_TABLE:    ratio_table_q    <= wr_data;
				REG_SIZE_TABLE:     size_table_q     <= wr_data;
				REG_RATIO_COUNT:    ratio_count_q    <= wr_data[COUNT_W-1:0];
				REG_SIZE_COUNT:     size_count_q     <= wr_data[COUNT_W-1:0];
				REG_STRIDE_X:       stride_x_q       <= wr_data[STRIDE_W-1:0];
				REG_STRIDE_Y:       stride_y_q       <= wr_data[STRIDE_W-1:0];
				REG_CENTER_OFFSET:  center_offset_q  <= wr_data[OFFSET_W-1:0];
				REG_VARIANCE_TABLE: variance_table_q <= wr_data;
				default: ;
			endcase
		end
	end

	// effective configuration
	logic [STRIDE_W-1:0]   sx_e;
	logic [STRIDE_W-1:0]   sy_e;
	logic [LANE_IDX_W-1:0] nr_last;
	logic [LANE_IDX_W-1:0] ns_last;

	assign sx_e = (stride_x_q == '0) ? STRIDE_W'(1) : stride_x_q;
	assign sy_e = (stride_y_q == '0) ? STRIDE_W'(1) : stride_y_q;
	assign nr_last = (ratio_count_q == '0) ? '0 :
		(ratio_count_q > COUNT_W'(RLIM)) ? LANE_IDX_W'(RLIM - 1) :
		LANE_IDX_W'(ratio_count_q - 3'd1);
	assign ns_last = (size_count_q == '0) ? '0 :
		(size_count_q > COUNT_W'(SLIM)) ? LANE_IDX_W'(SLIM - 1) :
		LANE_IDX_W'(size_count_q - 3'd1);

	// sequencer registers
	state_t                st_q;
	logic [LANE_IDX_W-1:0] r_q;
	logic [LANE_IDX_W-1:0] s_q;
	logic [CELL_W-1:0]     row_q;
	logic [CELL_W-1:0]     col_q;
	logic [26:0]           cx_a_q;
	logic [3:0]            cx_b_q;
	logic [26:0]           cy_a_q;
	logic [3:0]            cy_b_q;
	logic [19:0]           area_q;
	logic [BW_W-1:0]       bw_q;
	logic [CDIV_N-1:0]     px_q;
	logic [CDIV_N-1:0]     py_q;

	logic                  out_valid_q;
	logic [COORD_W-1:0]    x_min_q;
	logic [COORD_W-1:0]    y_min_q;
	logic [COORD_W-1:0]    x_max_q;
	logic [COORD_W-1:0]    y_max_q;
	logic [LANE_W-1:0]     var_a_q;
	logic [LANE_W-1:0]     var_b_q;
	logic [LANE_W-1:0]     var_c_q;
	logic [LANE_W-1:0]     var_d_q;
	logic                  last_anchor_q;

	// datapath wires
	logic [30:0]           cx8;
	logic [30:0]           cy8;
	logic [LANE_W-1:0]     rq_raw;
	logic [LANE_W-1:0]     rq_e;
	logic [LANE_W-1:0]     sz;
	logic [32:0]           bh_sum;
	logic [BH_W-1:0]       bh_new;
	logic [RAMW-1:0]       ram_rdata;
	logic [BW_W-1:0]       rd_bw;
	logic [BH_W-1:0]       rd_bh;
	logic [31:0]           prod_x;
	logic [40:0]           prod_y;

	logic                  rdiv_start;
	logic                  rdiv_done;
	logic [RDIV_N-1:0]     rdiv_q;
	logic                  sqrt_start;
	logic                  sqrt_done;
	logic [SQRT_W/2-1:0]   sqrt_root;
	logic                  cdiv_start;
	logic                  xdiv_done;
	logic                  ydiv_done;
	logic [CDIV_N-1:0]     xdiv_q;
	logic [STRIDE_W-1:0]   xdiv_r;
	logic [CDIV_N-1:0]     ydiv_q;
	logic [STRIDE_W-1:0]   ydiv_r;

	logic                  fin_load;
	logic                  fin_last;

	// center of the cell in q8, exact
	assign cx8 = ((31'(col_q) * 31'(sx_e)) << 8) +
		31'(center_offset_q) * 31'(sx_e - 10'd1);
	assign cy8 = ((31'(row_q) * 31'(sy_e)) << 8) +
		31'(center_offset_q) * 31'(sy_e - 10'd1);

	assign rq_raw = lane16(ratio_table_q, r_q);
	assign rq_e   = (rq_raw == '0) ? LANE_W'(1) : rq_raw;
	assign sz     = lane16(size_table_q, s_q);

	// base height, rounding half up
	assign bh_sum = {1'b0, 32'(bw_q) * 32'(rq_e)} + 33'd128;
	assign bh_new = bh_sum[32:8];

	assign rd_bw  = ram_rdata[BW_W-1:0];
	assign rd_bh  = ram_rdata[RAMW-1:BW_W];
	assign prod_x = 32'(sz) * 32'(rd_bw);
	assign prod_y = 41'(sz) * 41'(rd_bh);

	assign rdiv_start = (st_q == S_RSTART);
	assign sqrt_start = (st_q == S_RDIV) && rdiv_done;
	assign cdiv_start = (st_q == S_DSTART);

	assign fin_load = (st_q == S_FIN) && (!out_valid_q || !out_stall);
	assign fin_last = (r_q == nr_last) && (s_q == ns_last);

	abg_ram #(
		.WIDTH (RAMW),
		.DEPTH (RLIM)
	) u_base_ram (
		.clk   (clk),
		.we    (st_q == S_BH),
		.waddr (r_q[RAW-1:0]),
		.wdata ({bh_new, bw_q}),
		.raddr (r_q[RAW-1:0]),
		.rdata (ram_rdata)
	);

	abg_div #(
		.N (RDIV_N),
		.M (LANE_W)
	) u_abg_rdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rdiv_start),
		.dividend ({2'b00, area_q, 10'b0}),
		.divisor  (rq_e),
		.done     (rdiv_done),
		.quot     (rdiv_q),
		.rem      ()
	);

	abg_sqrt #(
		.W (SQRT_W)
	) u_abg_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.operand (rdiv_q),
		.done    (sqrt_done),
		.root    (sqrt_root)
	);

	abg_div #(
		.N (CDIV_N),
		.M (STRIDE_W)
	) u_abg_xdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cdiv_start),
		.dividend (px_q),
		.divisor  (sx_e),
		.done     (xdiv_done),
		.quot     (xdiv_q),
		.rem      (xdiv_r)
	);

	abg_div #(
		.N (CDIV_N),
		.M (STRIDE_W)
	) u_abg_ydiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cdiv_start),
		.dividend (py_q),
		.divisor  (sy_e),
		.done     (ydiv_done),
		.quot     (ydiv_q),
		.rem      (ydiv_r)
	);

	// corner = a + b/16 -/+ (q + r/d - 8), floored and saturated
	function automatic logic [COORD_W-1:0] corner(input logic [26:0] a,
		input logic [3:0] b, input logic [CDIV_N-1:0] q,
		input logic [STRIDE_W-1:0] r, input logic [STRIDE_W-1:0] d,
		input logic is_max);
		logic [14:0] bd;
		logic [14:0] r16;
		logic [14:0] dr16;
		logic        adj;
		logic [47:0] v;
		logic signed [47:0] vs;
		bd   = 15'(b) * 15'(d);
		r16  = {1'b0, r, 4'b0000};
		dr16 = {1'b0, d - r, 4'b0000};
		if (is_max) begin
			adj = (bd >= dr16);
			v = 48'(a) + 48'(q) - 48'd8 + 48'(adj);
		end else begin
			adj = (r16 > bd);
			v = 48'(a) - 48'(q) + 48'd8 - 48'(adj);
		end
		vs = signed'(v);
		if (vs > 48'sd134217727) begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end else if (vs < -48'sd134217728) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end
		return v[COORD_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= S_IDLE;
			r_q           <= '0;
			s_q           <= '0;
			out_valid_q   <= 1'b0;
			last_anchor_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						r_q  <= '0;
						s_q  <= '0;
						st_q <= S_CENTER;
					end
				end
				S_CENTER: begin
					st_q <= S_RSTART;
				end
				S_RSTART: begin
					st_q <= S_RDIV;
				end
				S_RDIV: begin
					if (rdiv_done) begin
						st_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						st_q <= S_BH;
					end
				end
				S_BH: begin
					if (r_q == nr_last) begin
						r_q  <= '0;
						st_q <= S_READ;
					end else begin
						r_q  <= r_q + 1'b1;
						st_q <= S_RSTART;
					end
				end
				S_READ: begin
					st_q <= S_MUL;
				end
				S_MUL: begin
					st_q <= S_DSTART;
				end
				S_DSTART: begin
					st_q <= S_DIV;
				end
				S_DIV: begin
					if (xdiv_done) begin
						st_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_load) begin
						out_valid_q   <= 1'b1;
						last_anchor_q <= fin_last;
						if (fin_last) begin
							st_q <= S_IDLE;
						end else begin
							if (s_q == ns_last) begin
								s_q <= '0;
								r_q <= r_q + 1'b1;
							end else begin
								s_q <= s_q + 1'b1;
							end
							st_q <= S_READ;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && in_valid) begin
			row_q <= row;
			col_q <= col;
		end
		if (st_q == S_CENTER) begin
			cx_a_q <= cx8[30:4];
			cx_b_q <= cx8[3:0];
			cy_a_q <= cy8[30:4];
			cy_b_q <= cy8[3:0];
			area_q <= 20'(sx_e) * 20'(sy_e);
		end
		if (st_q == S_SQRT && sqrt_done) begin
			bw_q <= BW_W'(({1'b0, sqrt_root} + 17'd1) >> 1);
		end
		if (st_q == S_MUL) begin
			px_q <= {9'b0, prod_x, 3'b000};
			py_q <= {prod_y, 3'b000};
		end
		if (fin_load) begin
			x_min_q <= corner(cx_a_q, cx_b_q, xdiv_q, xdiv_r, sx_e, 1'b0);
			x_max_q <= corner(cx_a_q, cx_b_q, xdiv_q, xdiv_r, sx_e, 1'b1);
			y_min_q <= corner(cy_a_q, cy_b_q, ydiv_q, ydiv_r, sy_e, 1'b0);
			y_max_q <= corner(cy_a_q, cy_b_q, ydiv_q, ydiv_r, sy_e, 1'b1);
			var_a_q <= lane16(variance_table_q, 2'd0);
			var_b_q <= lane16(variance_table_q, 2'd1);
			var_c_q <= lane16(variance_table_q, 2'd2);
			var_d_q <= lane16(variance_table_q, 2'd3);
		end
	end

	assign in_stall    = (st_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign x_min       = signed'(x_min_q);
	assign y_min       = signed'(y_min_q);
	assign x_max       = signed'(x_max_q);
	assign y_max       = signed'(y_max_q);
	assign var_a       = var_a_q;
	assign var_b       = var_b_q;
	assign var_c       = var_c_q;
	assign var_d       = var_d_q;
	assign last_anchor = last_anchor_q;

	// both corner dividers run in lockstep
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		xdiv_done == ydiv_done)
		else $error("corner dividers out of step");

	a_rdiv_state: assert property (@(posedge clk) disable iff (!arst_n)
		rdiv_done |-> st_q == S_RDIV)
		else $error("ratio divider finished outside its wait state");

	a_sqrt_state: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> st_q == S_SQRT)
		else $error("square root finished outside its wait state");

	a_last_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_load && fin_last) |=> (out_valid_q && last_anchor_q && st_q == S_IDLE))
		else $error("last box of a cell not flagged");

endmodule
